/* rtl/ptt_pkg.sv */
// Package for the periodic timer table: beat structs, command and event codes,
// the per-slot table entry type and the default table size.
// No dependencies; ptt_slot_update and periodic_timer_table_core import it, ptt_ram does not.
package ptt_pkg;

  localparam int TIMER_SLOTS_DEF = 16;
  localparam logic [31:0] FOREVER = 32'hFFFF_FFFF;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [2:0] EV_FIRED      = 3'd0;
  localparam logic [2:0] EV_ADDED      = 3'd1;
  localparam logic [2:0] EV_REMOVED    = 3'd2;
  localparam logic [2:0] EV_FULL       = 3'd3;
  localparam logic [2:0] EV_NOT_ACTIVE = 3'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] period_ticks;
    logic [31:0] repeat_limit;
    logic [3:0]  slot_to_remove;
  } ptt_in_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [3:0]  timer_slot;
    logic [31:0] fire_count;
    logic        last;
  } ptt_out_t;

  typedef struct packed {
    logic [31:0] period;
    logic [31:0] limit;
    logic [31:0] fired;
    logic [31:0] countdown;
  } ptt_entry_t;

  localparam int ENTRY_W = $bits(ptt_entry_t);

  // Outcome of updating one slot on a tick.
  typedef struct packed {
    logic fire;
    logic retire;
  } ptt_upd_stat_t;

endpackage

/* rtl/ptt_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/ptt_slot_update.sv */
// Per-slot tick update: decrements the countdown, or fires, reloads and
// decides whether the timer has used up its repeat limit. Uses ptt_pkg.
module ptt_slot_update (
  input  ptt_pkg::ptt_entry_t    cur,
  output ptt_pkg::ptt_entry_t    nxt,
  output ptt_pkg::ptt_upd_stat_t stat
);
  import ptt_pkg::*;

  logic [31:0] fired_inc;
  logic        fire;

  // A countdown of one fires; a countdown found at zero fires as well.
  assign fire      = (cur.countdown[31:1] == 31'd0);
  assign fired_inc = cur.fired + 32'd1;

  always_comb begin
    nxt         = cur;
    stat.fire   = fire;
    stat.retire = 1'b0;
    if (fire) begin
      nxt.fired     = fired_inc;
      nxt.countdown = cur.period;
      stat.retire   = (cur.limit != FOREVER) && (fired_inc >= cur.limit);
    end else begin
      nxt.countdown = cur.countdown - 32'd1;
    end
  end

endmodule

/* rtl/periodic_timer_table_core.sv */
// Top level of the periodic timer table: command decode, slot walk sequencer
// and result register. Uses ptt_pkg, ptt_ram and ptt_slot_update.
//
// A command beat is taken when start is high and busy is low. Add and remove
// are handled in the cycle they are taken and give one result beat in the
// following cycle; busy stays low for them. A tick walks every slot of the
// table in index order through the slot memory, one slot per cycle, and busy
// is high from the taking of the tick until the walk and its flush are done;
// the length of the walk is set by the single read port of the slot
// memory. Each timer that fires gives one result beat, and the beat of the
// last firing timer carries last; a tick on which nothing fires gives no
// beat at all. Result beats appear on out_valid for exactly one cycle each
// and cannot be held off, so the receiver must take every beat as it comes.
// An unused command code is dropped without a result.
module periodic_timer_table_core #(
  parameter int TIMER_SLOTS = ptt_pkg::TIMER_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ptt_pkg::ptt_in_t   in_data,
  output logic               out_valid,
  output ptt_pkg::ptt_out_t  out_data
);
  import ptt_pkg::*;

  localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  // The walk counter runs up to TIMER_SLOTS + 1 for the last update and the flush cycle.
  localparam int CNT_W  = $clog2(TIMER_SLOTS + 2);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  // Slot index to the four-bit result field.
  function automatic logic [3:0] slot4(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W+3:0] wide;
    wide = {4'b0000, idx};
    return wide[3:0];
  endfunction

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     scan_idx_r, scan_idx_nxt;
  logic                 proc_valid_r, proc_valid_nxt;
  logic [SLOT_W-1:0]    proc_idx_r, proc_idx_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  ptt_out_t             pend_r, pend_nxt;
  logic [TIMER_SLOTS-1:0] active_r, active_nxt;
  logic                 out_valid_r, out_valid_nxt;
  ptt_out_t             out_data_r, out_data_nxt;

  logic                 ram_we, ram_re;
  logic [SLOT_W-1:0]    ram_waddr, ram_raddr;
  ptt_entry_t           ram_wdata, ram_rdata;
  ptt_entry_t           upd_next;
  ptt_upd_stat_t        upd_stat;

  logic                 have_free;
  logic [SLOT_W-1:0]    free_idx;
  logic [SLOT_W+3:0]    rm_wide;
  logic [SLOT_W-1:0]    rm_idx;
  logic                 rm_ok;
  logic [31:0]          add_period, add_limit;

  // Slot memory. During a walk the read of slot k and the write-back of slot
  // k-1 share a cycle; they never touch the same entry, so no forwarding is
  // needed. Adds write only while the walk is idle.
  ptt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TIMER_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ptt_slot_update u_slot_update (
    .cur  (ram_rdata),
    .nxt  (upd_next),
    .stat (upd_stat)
  );

  // Lowest free slot: scanning downwards lets the lowest index win.
  always_comb begin
    have_free = 1'b0;
    free_idx  = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        have_free = 1'b1;
        free_idx  = SLOT_W'(i);
      end
    end
  end

  // A remove names a slot in four bits; it may lie beyond a smaller table.
  assign rm_wide = {{SLOT_W{1'b0}}, in_data.slot_to_remove};
  assign rm_idx  = rm_wide[SLOT_W-1:0];
  assign rm_ok   = (rm_wide < (SLOT_W + 4)'(TIMER_SLOTS)) && active_r[rm_idx];

  assign add_period = (in_data.period_ticks == 32'd0) ? 32'd1 : in_data.period_ticks;
  assign add_limit  = (in_data.repeat_limit == 32'd0) ? 32'd1 : in_data.repeat_limit;

  always_comb begin
    state_nxt      = state_r;
    scan_idx_nxt   = scan_idx_r;
    proc_valid_nxt = 1'b0;
    proc_idx_nxt   = proc_idx_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    active_nxt     = active_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = proc_idx_r;
    ram_wdata      = upd_next;
    ram_re         = 1'b0;
    ram_raddr      = scan_idx_r[SLOT_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_data.command)
            CMD_TICK: begin
              state_nxt      = ST_SCAN;
              scan_idx_nxt   = '0;
              pend_valid_nxt = 1'b0;
            end
            CMD_ADD: begin
              out_valid_nxt           = 1'b1;
              out_data_nxt.fire_count = 32'd0;
              out_data_nxt.last       = 1'b1;
              if (have_free) begin
                active_nxt[free_idx]    = 1'b1;
                ram_we                  = 1'b1;
                ram_waddr               = free_idx;
                ram_wdata.period        = add_period;
                ram_wdata.limit         = add_limit;
                ram_wdata.fired         = 32'd0;
                ram_wdata.countdown     = add_period;
                out_data_nxt.event_kind = EV_ADDED;
                out_data_nxt.timer_slot = slot4(free_idx);
              end else begin
                out_data_nxt.event_kind = EV_FULL;
                out_data_nxt.timer_slot = 4'd0;
              end
            end
            CMD_REMOVE: begin
              out_valid_nxt           = 1'b1;
              out_data_nxt.timer_slot = in_data.slot_to_remove;
              out_data_nxt.fire_count = 32'd0;
              out_data_nxt.last       = 1'b1;
              if (rm_ok) begin
                active_nxt[rm_idx]      = 1'b0;
                out_data_nxt.event_kind = EV_REMOVED;
              end else begin
                out_data_nxt.event_kind = EV_NOT_ACTIVE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        scan_idx_nxt = scan_idx_r + CNT_W'(1);

        // Read stage: fetch the next slot of the walk.
        if (scan_idx_r < CNT_W'(TIMER_SLOTS)) begin
          ram_re         = 1'b1;
          proc_valid_nxt = 1'b1;
          proc_idx_nxt   = scan_idx_r[SLOT_W-1:0];
        end

        // Update stage: the slot read last cycle. A firing is held in pend_r until
        // the next firing or the flush, so that the final one can be marked as last.
        if (proc_valid_r && active_r[proc_idx_r]) begin
          ram_we = 1'b1;
          if (upd_stat.fire) begin
            if (pend_valid_r) begin
              out_valid_nxt     = 1'b1;
              out_data_nxt      = pend_r;
              out_data_nxt.last = 1'b0;
            end
            pend_valid_nxt      = 1'b1;
            pend_nxt.event_kind = EV_FIRED;
            pend_nxt.timer_slot = slot4(proc_idx_r);
            pend_nxt.fire_count = ram_rdata.fired;
            pend_nxt.last       = 1'b0;
            if (upd_stat.retire) begin
              active_nxt[proc_idx_r] = 1'b0;
            end
          end
        end

        // Flush: release the held firing with last set and finish.
        if (scan_idx_r == CNT_W'(TIMER_SLOTS + 1)) begin
          state_nxt      = ST_IDLE;
          pend_valid_nxt = 1'b0;
          if (pend_valid_r) begin
            out_valid_nxt     = 1'b1;
            out_data_nxt      = pend_r;
            out_data_nxt.last = 1'b1;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      scan_idx_r   <= '0;
      proc_valid_r <= 1'b0;
      pend_valid_r <= 1'b0;
      active_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_idx_r   <= scan_idx_nxt;
      proc_valid_r <= proc_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      active_r     <= active_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    proc_idx_r <= proc_idx_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for periodic_timer_table_core: a tick/add/remove command stream
// with predicted timer events, compared beat by beat. Depends on rtl/ptt_pkg.sv and the RTL
// of the timer table; needs no other files.
`timescale 1ns / 1ps

module tb_top;
  import ptt_pkg::*;

  localparam int SLOTS = TIMER_SLOTS_DEF;
  // Command code 3 has no meaning; the block must drop it without a result.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // Allow well over the length of a tick walk before the final verdict.
  localparam int DRAIN_CYCLES = 3 * (SLOTS + 2);
  // Watchdog limit, many times the length of the slowest legal run.
  localparam int WATCHDOG_CYCLES = 200_000;

  // Holds its own copy of the timer table, works out the event beats that each accepted
  // command must produce and checks the observed beats against them in order.
  class timer_event_board;
    bit          slot_busy [SLOTS];
    logic [31:0] reload_period [SLOTS];
    logic [31:0] fire_limit [SLOTS];
    logic [31:0] fire_total [SLOTS];
    logic [31:0] ticks_left [SLOTS];
    ptt_out_t    pending_events [$];
    int unsigned mismatches, beats_checked, fires_checked, full_checked;
    int unsigned ticks_sent, adds_sent, removes_sent, unused_sent;

    function ptt_out_t event_beat(logic [2:0] kind, int slot, logic [31:0] count);
      ptt_out_t ev;
      ev.event_kind = kind;
      ev.timer_slot = 4'(slot);
      ev.fire_count = count;
      ev.last       = 1'b0;
      return ev;
    endfunction

    function bit slots_all_busy();
      bit all_busy;
      all_busy = 1'b1;
      for (int i = 0; i < SLOTS; i++) if (!slot_busy[i]) all_busy = 1'b0;
      return all_busy;
    endfunction

    function void note_command(ptt_in_t c);
      ptt_out_t    batch [$];
      logic [31:0] per, lim;
      int          free_slot;
      case (c.command)
        CMD_TICK: begin
          ticks_sent++;
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_busy[i]) begin
              if (ticks_left[i] > 32'd1) begin
                ticks_left[i] = ticks_left[i] - 32'd1;
              end else begin
                // A countdown of one (or zero) expires now.
                batch.insert(batch.size(), event_beat(EV_FIRED, i, fire_total[i]));
                fire_total[i] = fire_total[i] + 32'd1;
                if (fire_limit[i] != FOREVER && fire_total[i] >= fire_limit[i])
                  slot_busy[i] = 1'b0;
                else
                  ticks_left[i] = reload_period[i];
              end
            end
          end
        end
        CMD_ADD: begin
          adds_sent++;
          per = (c.period_ticks == 32'd0) ? 32'd1 : c.period_ticks;
          lim = (c.repeat_limit == 32'd0) ? 32'd1 : c.repeat_limit;
          free_slot = -1;
          for (int i = SLOTS - 1; i >= 0; i--) if (!slot_busy[i]) free_slot = i;
          if (free_slot < 0) begin
            batch.insert(batch.size(), event_beat(EV_FULL, 0, 32'd0));
          end else begin
            slot_busy[free_slot]     = 1'b1;
            reload_period[free_slot] = per;
            fire_limit[free_slot]    = lim;
            fire_total[free_slot]    = 32'd0;
            ticks_left[free_slot]    = per;
            batch.insert(batch.size(), event_beat(EV_ADDED, free_slot, 32'd0));
          end
        end
        CMD_REMOVE: begin
          removes_sent++;
          if (slot_busy[c.slot_to_remove]) begin
            slot_busy[c.slot_to_remove] = 1'b0;
            batch.insert(batch.size(), event_beat(EV_REMOVED, c.slot_to_remove, 32'd0));
          end else begin
            batch.insert(batch.size(), event_beat(EV_NOT_ACTIVE, c.slot_to_remove, 32'd0));
          end
        end
        default: unused_sent++;
      endcase
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[k]) pending_events.insert(pending_events.size(), batch[k]);
    endfunction

    function void check_event(ptt_out_t got);
      ptt_out_t want;
      beats_checked++;
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: kind %0d slot %0d count %0d last %0d",
                   got.event_kind, got.timer_slot, got.fire_count, got.last);
        return;
      end
      want = pending_events.pop_front();
      if (want.event_kind == EV_FIRED) fires_checked++;
      if (want.event_kind == EV_FULL) full_checked++;
      if (got.event_kind !== want.event_kind || got.timer_slot !== want.timer_slot ||
          got.fire_count !== want.fire_count || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result beat %0d differs: expected kind %0d slot %0d count %0d last %0d,",
                    " got kind %0d slot %0d count %0d last %0d"}, beats_checked,
                   want.event_kind, want.timer_slot, want.fire_count, want.last,
                   got.event_kind, got.timer_slot, got.fire_count, got.last);
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  ptt_in_t  in_data;
  logic     out_valid;
  ptt_out_t out_data;

  timer_event_board board;
  // Chance in a hundred that the command side sits idle on a given cycle.
  int unsigned      idle_pct;

  periodic_timer_table_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result beats cannot be held off, so every cycle with out_valid high is a beat that
  // has been taken and must be checked. Outputs are read at the edge, before the block's
  // own updates for that edge land.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) board.check_event(out_data);
  end

  // Guard against a hang: a block that stops answering ends the run as a failure.
  initial begin
    repeat (WATCHDOG_CYCLES) @(posedge clk);
    $display("FAILED: results differ");
    $finish;
  end

  // A command with every field random; callers then overwrite the fields that matter.
  function automatic ptt_in_t noise_fields();
    ptt_in_t c;
    c.command        = 2'($urandom_range(3, 0));
    c.period_ticks   = $urandom();
    c.repeat_limit   = $urandom();
    c.slot_to_remove = 4'($urandom_range(15, 0));
    return c;
  endfunction

  function automatic ptt_in_t tick_beat();
    ptt_in_t c;
    c = noise_fields();
    c.command = CMD_TICK;
    return c;
  endfunction

  function automatic ptt_in_t add_beat(logic [31:0] per, logic [31:0] lim);
    ptt_in_t c;
    c = noise_fields();
    c.command      = CMD_ADD;
    c.period_ticks = per;
    c.repeat_limit = lim;
    return c;
  endfunction

  function automatic ptt_in_t remove_beat(logic [3:0] slot);
    ptt_in_t c;
    c = noise_fields();
    c.command        = CMD_REMOVE;
    c.slot_to_remove = slot;
    return c;
  endfunction

  // Mostly short periods and small limits so that timers fire and retire often; forever
  // timers keep the table busy, and the odd full-width value exercises every bit.
  function automatic ptt_in_t random_add();
    logic [31:0] per, lim;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70)      per = $urandom_range(6, 0);
    else if (r < 90) per = $urandom_range(40, 7);
    else             per = $urandom();
    r = $urandom_range(99);
    if (r < 40)      lim = $urandom_range(4, 0);
    else if (r < 65) lim = FOREVER;
    else if (r < 85) lim = $urandom_range(20, 5);
    else             lim = $urandom();
    return add_beat(per, lim);
  endfunction

  // Removes mostly aim at live timers so that slots are freed and reused; the rest hit
  // any slot, live or not.
  function automatic ptt_in_t random_command();
    int          live [$];
    int unsigned r;
    ptt_in_t     c;
    r = $urandom_range(99);
    if (r < 45) begin
      c = tick_beat();
    end else if (r < 75) begin
      c = random_add();
    end else if (r < 93) begin
      for (int i = 0; i < SLOTS; i++) if (board.slot_busy[i]) live.insert(live.size(), i);
      if (live.size() > 0 && $urandom_range(99) < 80)
        c = remove_beat(4'(live[$urandom_range(live.size() - 1, 0)]));
      else
        c = remove_beat(4'($urandom_range(15, 0)));
    end else begin
      c = noise_fields();
      c.command = CMD_UNUSED;
    end
    return c;
  endfunction

  // Presents one command and returns at the edge that takes it. Idle cycles come first,
  // with junk on in_data; start then stays high through any busy stretch. The next call
  // decides whether start drops, so start is assigned only once per edge.
  task automatic issue_command(ptt_in_t c);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start   <= 1'b0;
      in_data <= noise_fields();
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    board.note_command(c);
  endtask

  // Random commands at a given idle rate. Somewhere in the first half the table is
  // filled on purpose and one further add is made to hit the full-table error.
  // Unused command codes do not count towards the total.
  task automatic run_random_phase(int unsigned pct, int unsigned total);
    int unsigned sent, fill_at;
    ptt_in_t     c;
    idle_pct = pct;
    sent     = 0;
    fill_at  = $urandom_range(total / 2, total / 4);
    while (sent < total) begin
      if (sent == fill_at) begin
        while (!board.slots_all_busy()) begin
          issue_command(random_add());
          sent++;
        end
        issue_command(random_add());
        sent++;
      end else begin
        c = random_command();
        issue_command(c);
        if (c.command != CMD_UNUSED) sent++;
      end
    end
  endtask

  initial begin
    board    = new();
    idle_pct = 0;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, back to back. Removes on an empty table, a tick with nothing to
    // fire, and an unused code come first.
    issue_command(remove_beat(4'd0));
    issue_command(remove_beat(4'd15));
    issue_command(tick_beat());
    begin
      ptt_in_t odd;
      odd = noise_fields();
      odd.command = CMD_UNUSED;
      issue_command(odd);
    end
    // Zero period and zero limit both read as one; a forever timer; full-width values
    // that never fire within the run; two ordinary timers.
    issue_command(add_beat(32'd0, 32'd0));
    issue_command(add_beat(32'd1, FOREVER));
    issue_command(add_beat(32'hFFFF_FFFF, FOREVER));
    issue_command(add_beat(32'd2, 32'd3));
    issue_command(add_beat(32'd3, 32'd2));
    // Two timers fire on each of these ticks; the one-shot in slot 0 retires.
    issue_command(tick_beat());
    issue_command(tick_beat());
    // The freed slot 0 is the lowest free one and is taken again.
    issue_command(add_beat(32'd1, 32'd1));
    issue_command(remove_beat(4'd2));
    issue_command(remove_beat(4'd2));
    issue_command(tick_beat());
    issue_command(remove_beat(4'd1));
    issue_command(tick_beat());
    issue_command(tick_beat());

    // Random part in three traffic patterns: continuous, sparse and lightly gapped.
    run_random_phase(0, 140);
    run_random_phase(86, 140);
    run_random_phase(8, 140);

    start <= 1'b0;
    while (board.pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d ticks, %0d adds, %0d removes and %0d unused codes.",
             board.ticks_sent, board.adds_sent, board.removes_sent, board.unused_sent);
    $display("Checked %0d result beats: %0d timer fires, %0d full-table refusals.",
             board.beats_checked, board.fires_checked, board.full_checked);
    if (board.pending_events.size() != 0)
      $display("%0d expected result beats never arrived", board.pending_events.size());
    if (board.mismatches > 10)
      $display("%0d result beats were wrong in all", board.mismatches);
    if (board.mismatches == 0 && board.pending_events.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
